// ----- src/fct_pkg.sv -----
package fct_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int TIME_W  = 32;
    localparam int TO_W    = 20;
    localparam int GC_W    = 16;
    localparam int LIM_W   = 11;
    localparam int KEY_W   = 104;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0] TCP_PROTO_NUM = 8'd6;
    localparam logic [7:0] UDP_PROTO_NUM = 8'd17;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_EST     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TO_EST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TO_NEW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TO_UDP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TO_OTHER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TO_CLOSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GC       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAXF     = 3'd6;

    localparam logic [TO_W-1:0]  TO_EST_RESET   = 20'd432000;
    localparam logic [TO_W-1:0]  TO_NEW_RESET   = 20'd120;
    localparam logic [TO_W-1:0]  TO_UDP_RESET   = 20'd30;
    localparam logic [TO_W-1:0]  TO_OTHER_RESET = 20'd10;
    localparam logic [TO_W-1:0]  TO_CLOSE_RESET = 20'd5;
    localparam logic [GC_W-1:0]  GC_RESET       = 16'd60;
    localparam logic [LIM_W-1:0] MAXF_RESET     = 11'd1024;

    typedef struct packed {
        logic [TO_W-1:0]  to_est;
        logic [TO_W-1:0]  to_new;
        logic [TO_W-1:0]  to_udp;
        logic [TO_W-1:0]  to_other;
        logic [TO_W-1:0]  to_close;
        logic [GC_W-1:0]  gc;
        logic [LIM_W-1:0] maxf;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [1:0]        cst;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } eng_state_t;

    function automatic logic [TO_W-1:0] lifetime(cfg_t c, logic [7:0] proto, logic [1:0] st);
        logic [TO_W-1:0] t;
        if (proto == TCP_PROTO_NUM) begin
            t = (st == ST_EST) ? c.to_est : c.to_new;
        end else if (proto == UDP_PROTO_NUM) begin
            t = c.to_udp;
        end else begin
            t = c.to_other;
        end
        return t;
    endfunction

endpackage

// ----- src/fct_ram.sv -----
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fct_engine.sv -----
module fct_engine import fct_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_cmd,
    input  logic [KEY_W-1:0] in_key_fwd,
    input  logic [KEY_W-1:0] in_key_rev,
    input  logic [7:0]       in_proto,
    input  logic [3:0]       in_flags,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_state,
    output logic             out_reply,
    output logic [LIM_W-1:0] out_live,
    output logic [LIM_W-1:0] out_evict
);

    eng_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  kf_reg, kf_next;
    logic [KEY_W-1:0]  kr_reg, kr_next;
    logic [7:0]        proto_reg, proto_next;
    logic [3:0]        flags_reg, flags_next;
    logic              fhit_reg, fhit_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic [1:0]        fst_reg, fst_next;
    logic              rhit_reg, rhit_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic [1:0]        rst_reg, rst_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  fridx_reg, fridx_next;
    logic [LIM_W-1:0]  total_reg, total_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [GC_W-1:0]   tts_reg, tts_next;
    logic [LIM_W-1:0]  evict_reg, evict_next;
    logic              ov_reg, ov_next;
    logic [1:0]        os_reg, os_next;
    logic              orep_reg, orep_next;
    logic [LIM_W-1:0]  olive_reg, olive_next;
    logic [LIM_W-1:0]  oev_reg, oev_next;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata, rdata;
    logic              issue, scan_done, out_free;
    logic [TIME_W-1:0] age;
    logic              expired;
    logic [LIM_W-1:0]  limit;
    logic              syn, ack, fin, rst, tcp;
    logic [1:0]        hit_st, new_st;
    logic [TO_W-1:0]   to_sel;

    fct_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign issue     = (cnt_reg != CNT_W'(ENTRIES));
    assign scan_done = !issue && !pend_reg;
    assign out_free  = !ov_reg || out_ready;
    assign raddr     = cnt_reg[IDX_W-1:0];
    assign age       = time_reg - rdata.expiry;
    assign expired   = rdata.valid && (age != '0) && !age[TIME_W-1];
    assign limit     = (cfg.maxf > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cfg.maxf;
    assign {rst, fin, ack, syn} = flags_reg;
    assign tcp       = (proto_reg == TCP_PROTO_NUM);
    assign hit_st    = fhit_reg ? fst_reg : rst_reg;

    always_comb begin
        new_st = hit_st;
        if (tcp) begin
            if (syn && !ack) begin
                new_st = ST_NEW;
            end else if (ack) begin
                new_st = ST_EST;
            end else if (fin || rst) begin
                new_st = ST_INVALID;
            end
        end else if (!fhit_reg) begin
            new_st = ST_EST;
        end
        if (tcp && !syn && !ack && (fin || rst)) begin
            to_sel = cfg.to_close;
        end else begin
            to_sel = lifetime(cfg, proto_reg, new_st);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == CNT_W'(ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    if (in_cmd && tts_reg > GC_W'(1)) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        cmd_next   = cmd_reg;
        kf_next    = kf_reg;
        kr_next    = kr_reg;
        proto_next = proto_reg;
        flags_next = flags_reg;
        fhit_next  = fhit_reg;
        fidx_next  = fidx_reg;
        fst_next   = fst_reg;
        rhit_next  = rhit_reg;
        ridx_next  = ridx_reg;
        rst_next   = rst_reg;
        free_next  = free_reg;
        fridx_next = fridx_reg;
        total_next = total_reg;
        time_next  = time_reg;
        tts_next   = tts_reg;
        evict_next = evict_reg;
        ov_next    = ov_reg && !out_ready;
        os_next    = os_reg;
        orep_next  = orep_reg;
        olive_next = olive_reg;
        oev_next   = oev_reg;
        in_ready   = 1'b0;
        we         = 1'b0;
        waddr      = cnt_reg[IDX_W-1:0];
        wdata      = '0;

        case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE: begin
                in_ready   = 1'b1;
                cnt_next   = '0;
                fhit_next  = 1'b0;
                rhit_next  = 1'b0;
                free_next  = 1'b0;
                evict_next = '0;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    kf_next    = in_key_fwd;
                    kr_next    = in_key_rev;
                    proto_next = in_proto;
                    flags_next = in_flags;
                    if (in_cmd) begin
                        time_next = time_reg + 1'b1;
                        if (tts_reg > GC_W'(1)) begin
                            tts_next = tts_reg - 1'b1;
                        end else begin
                            tts_next = cfg.gc;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    if (cmd_reg) begin
                        if (expired) begin
                            we         = 1'b1;
                            waddr      = pidx_reg;
                            wdata      = rdata;
                            wdata.valid = 1'b0;
                            total_next = total_reg - 1'b1;
                            evict_next = evict_reg + 1'b1;
                        end
                    end else begin
                        if (rdata.valid && rdata.key == kf_reg) begin
                            fhit_next = 1'b1;
                            fidx_next = pidx_reg;
                            fst_next  = rdata.cst;
                        end
                        if (rdata.valid && rdata.key == kr_reg) begin
                            rhit_next = 1'b1;
                            ridx_next = pidx_reg;
                            rst_next  = rdata.cst;
                        end
                        if (!rdata.valid && !free_reg) begin
                            free_next  = 1'b1;
                            fridx_next = pidx_reg;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    oev_next   = evict_reg;
                    orep_next  = 1'b0;
                    os_next    = ST_NEW;
                    olive_next = total_reg;
                    if (!cmd_reg) begin
                        wdata.valid = 1'b1;
                        if (fhit_reg || rhit_reg) begin
                            we           = 1'b1;
                            waddr        = fhit_reg ? fidx_reg : ridx_reg;
                            wdata.key    = fhit_reg ? kf_reg : kr_reg;
                            wdata.cst    = new_st;
                            wdata.expiry = time_reg + TIME_W'(to_sel);
                            os_next      = new_st;
                            orep_next    = !fhit_reg;
                        end else if (total_reg < limit && free_reg) begin
                            we           = 1'b1;
                            waddr        = fridx_reg;
                            wdata.key    = kf_reg;
                            wdata.cst    = ST_NEW;
                            wdata.expiry = time_reg
                                         + TIME_W'(lifetime(cfg, proto_reg, ST_NEW));
                            total_next   = total_reg + 1'b1;
                            olive_next   = total_reg + 1'b1;
                        end else begin
                            os_next = ST_INVALID;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            total_reg <= '0;
            time_reg  <= '0;
            tts_reg   <= GC_RESET;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            total_reg <= total_next;
            time_reg  <= time_next;
            tts_reg   <= tts_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg  <= pidx_next;
        cmd_reg   <= cmd_next;
        kf_reg    <= kf_next;
        kr_reg    <= kr_next;
        proto_reg <= proto_next;
        flags_reg <= flags_next;
        fhit_reg  <= fhit_next;
        fidx_reg  <= fidx_next;
        fst_reg   <= fst_next;
        rhit_reg  <= rhit_next;
        ridx_reg  <= ridx_next;
        rst_reg   <= rst_next;
        free_reg  <= free_next;
        fridx_reg <= fridx_next;
        evict_reg <= evict_next;
        os_reg    <= os_next;
        orep_reg  <= orep_next;
        olive_reg <= olive_next;
        oev_reg   <= oev_next;
    end

    assign out_valid = ov_reg;
    assign out_state = os_reg;
    assign out_reply = orep_reg;
    assign out_live  = olive_reg;
    assign out_evict = oev_reg;

endmodule

// ----- src/flow_connection_tracker.sv -----
// A packet is handled by one full scan of the flow memory before its result is registered.
// A tick without a sweep skips the scan; a sweep tick scans the whole flow memory.
// One request is handled at a time, and the next is taken while a result still waits in
// the output register.
// Reset: synchronous, active low; a clearing pass then marks all entries free.
// Configuration writes are taken during the clearing pass.
module flow_connection_tracker import fct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // source_address, dest_address, source_port, dest_port, protocol_number,
    // flag_syn, flag_ack, flag_fin, flag_rst
    input  logic [111:0]          s_tdata,
    // command
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // conn_state, reply_direction, live_flows, evicted_count
    output logic [31:0]           m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic [31:0]      sa, da;
    logic [15:0]      sp, dp;
    logic [7:0]       proto;
    logic [1:0]       st;
    logic             rep;
    logic [LIM_W-1:0] live, ev;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                REG_TO_EST:   cfg_next.to_est   = cfg_data;
                REG_TO_NEW:   cfg_next.to_new   = cfg_data;
                REG_TO_UDP:   cfg_next.to_udp   = cfg_data;
                REG_TO_OTHER: cfg_next.to_other = cfg_data;
                REG_TO_CLOSE: cfg_next.to_close = cfg_data;
                REG_GC:       cfg_next.gc       = cfg_data[GC_W-1:0];
                REG_MAXF:     cfg_next.maxf     = cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.to_est   <= TO_EST_RESET;
            cfg_reg.to_new   <= TO_NEW_RESET;
            cfg_reg.to_udp   <= TO_UDP_RESET;
            cfg_reg.to_other <= TO_OTHER_RESET;
            cfg_reg.to_close <= TO_CLOSE_RESET;
            cfg_reg.gc       <= GC_RESET;
            cfg_reg.maxf     <= MAXF_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign sa    = s_tdata[31:0];
    assign da    = s_tdata[63:32];
    assign sp    = s_tdata[79:64];
    assign dp    = s_tdata[95:80];
    assign proto = s_tdata[103:96];

    fct_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_key_fwd ({sa, da, sp, dp, proto}),
        .in_key_rev ({da, sa, dp, sp, proto}),
        .in_proto   (proto),
        .in_flags   (s_tdata[107:104]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_state  (st),
        .out_reply  (rep),
        .out_live   (live),
        .out_evict  (ev)
    );

    assign m_tdata = {7'd0, ev, live, rep, st};

endmodule

// ----- bench/tb_fct_pkg.sv -----
package tb_fct_pkg;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

endpackage

// ----- bench/fct_checker.sv -----
module fct_checker import fct_pkg::*, tb_fct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [111:0]          s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LIM_W-1:0] evicted;
        logic [LIM_W-1:0] live;
        logic             reply;
        logic [1:0]       st;
    } verdict_t;

    verdict_t awaited[$];

    logic [TO_W-1:0]   to_est, to_new, to_udp, to_other, to_close;
    logic [GC_W-1:0]   gc;
    logic [LIM_W-1:0]  maxf;
    logic [KEY_W-1:0]  flow_key[ENTRIES];
    logic [1:0]        flow_st[ENTRIES];
    logic [TIME_W-1:0] flow_exp[ENTRIES];
    logic              flow_live[ENTRIES];
    int                live_total;
    logic [TIME_W-1:0] now;
    int                sweep_wait;

    function automatic logic [TO_W-1:0] flow_lifetime(logic [7:0] proto, logic [1:0] st);
        if (proto == TCP_PROTO_NUM) return (st == ST_EST) ? to_est : to_new;
        if (proto == UDP_PROTO_NUM) return to_udp;
        return to_other;
    endfunction

    function automatic int lookup(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (flow_live[i] && flow_key[i] == k) return i;
        return -1;
    endfunction

    function automatic verdict_t track(logic cmd, logic [111:0] d);
        verdict_t v;
        logic [31:0] sa, da, age;
        logic [15:0] sp, dp;
        logic [7:0] proto;
        logic syn, ack, fin, rst, closing;
        int k, slot, limit;
        v = '0;
        if (cmd == CMD_TICK) begin
            now = now + 1'b1;
            if (sweep_wait <= 1) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    age = now - flow_exp[i];
                    if (flow_live[i] && age != 0 && !age[TIME_W-1]) begin
                        flow_live[i] = 1'b0;
                        live_total--;
                        v.evicted++;
                    end
                end
                sweep_wait = int'(gc);
            end else begin
                sweep_wait--;
            end
        end else begin
            {rst, fin, ack, syn, proto, dp, sp, da, sa} = d[107:0];
            k = lookup({sa, da, sp, dp, proto});
            if (k < 0) begin
                k = lookup({da, sa, dp, sp, proto});
                v.reply = (k >= 0);
            end
            if (k >= 0) begin
                closing = 1'b0;
                v.st = flow_st[k];
                if (proto == TCP_PROTO_NUM) begin
                    if (syn && !ack) v.st = ST_NEW;
                    else if (ack) v.st = ST_EST;
                    else if (fin || rst) closing = 1'b1;
                end else if (v.reply) begin
                    v.st = ST_EST;
                end
                if (closing) begin
                    v.st = ST_INVALID;
                    flow_exp[k] = now + TIME_W'(to_close);
                end else begin
                    flow_exp[k] = now + TIME_W'(flow_lifetime(proto, v.st));
                end
                flow_st[k] = v.st;
            end else begin
                limit = (maxf < ENTRIES) ? int'(maxf) : ENTRIES;
                slot = -1;
                if (live_total < limit)
                    for (int i = 0; i < ENTRIES && slot < 0; i++)
                        if (!flow_live[i]) slot = i;
                if (slot < 0) begin
                    v.st = ST_INVALID;
                end else begin
                    flow_live[slot] = 1'b1;
                    flow_key[slot] = {sa, da, sp, dp, proto};
                    flow_st[slot] = ST_NEW;
                    flow_exp[slot] = now + TIME_W'(flow_lifetime(proto, ST_NEW));
                    live_total++;
                    v.st = ST_NEW;
                end
            end
        end
        v.live = LIM_W'(live_total);
        return v;
    endfunction

    task automatic compare(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    initial failures = 0;

    always @(posedge aclk) begin
        verdict_t e, a;
        if (!aresetn) begin
            to_est = TO_EST_RESET;
            to_new = TO_NEW_RESET;
            to_udp = TO_UDP_RESET;
            to_other = TO_OTHER_RESET;
            to_close = TO_CLOSE_RESET;
            gc = GC_RESET;
            maxf = MAXF_RESET;
            foreach (flow_live[i]) flow_live[i] = 1'b0;
            live_total = 0;
            now = '0;
            sweep_wait = int'(GC_RESET);
            awaited.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                a = m_tdata[24:0];
                if (awaited.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    failures++;
                end else begin
                    e = awaited.pop_front();
                    compare("conn_state", e.st, a.st);
                    compare("reply_direction", e.reply, a.reply);
                    compare("live_flows", e.live, a.live);
                    compare("evicted_count", e.evicted, a.evicted);
                end
            end
            if (s_tvalid && s_tready) awaited.push_back(track(s_tuser[0], s_tdata));
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_TO_EST:   to_est = cfg_data;
                    REG_TO_NEW:   to_new = cfg_data;
                    REG_TO_UDP:   to_udp = cfg_data;
                    REG_TO_OTHER: to_other = cfg_data;
                    REG_TO_CLOSE: to_close = cfg_data;
                    REG_GC:       gc = cfg_data[GC_W-1:0];
                    REG_MAXF:     maxf = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = awaited.size();
    end

endmodule

// ----- bench/tb_flow_connection_tracker.sv -----
module tb_flow_connection_tracker;
    import fct_pkg::*;
    import tb_fct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     POOL = 24;

    typedef struct {
        logic [31:0] sa, da;
        logic [15:0] sp, dp;
        logic [7:0]  proto;
    } tuple_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [111:0]          s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    failures, pending;
    int                    tx_idle = 0, rx_idle = 0;
    longint                cycles = 0;
    tuple_t                pool[POOL];

    flow_connection_tracker dut (.*);

    fct_checker checker_i (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** flow_connection_tracker: FAILED **");
            $finish;
        end
    end

    task automatic push(logic cmd, logic [111:0] d);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic packet(tuple_t t, logic rev, logic [3:0] flags);
        if (rev) push(CMD_PACKET, {4'b0, flags, t.proto, t.sp, t.dp, t.sa, t.da});
        else     push(CMD_PACKET, {4'b0, flags, t.proto, t.dp, t.sp, t.da, t.sa});
    endtask

    task automatic tick();
        push(CMD_TICK, 112'({$urandom, $urandom, $urandom, $urandom}));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int est, int nw, int udp, int oth, int cls, int gcv, int mf);
        drain();
        write_reg(REG_TO_EST, CFG_DATA_W'(est));
        write_reg(REG_TO_NEW, CFG_DATA_W'(nw));
        write_reg(REG_TO_UDP, CFG_DATA_W'(udp));
        write_reg(REG_TO_OTHER, CFG_DATA_W'(oth));
        write_reg(REG_TO_CLOSE, CFG_DATA_W'(cls));
        write_reg(REG_GC, CFG_DATA_W'(gcv));
        write_reg(REG_MAXF, CFG_DATA_W'(mf));
    endtask

    function automatic tuple_t fresh_tuple();
        tuple_t t;
        t.sa = $urandom;
        t.da = $urandom;
        t.sp = 16'($urandom);
        t.dp = 16'($urandom);
        case ($urandom_range(3))
            0, 1: t.proto = TCP_PROTO_NUM;
            2:    t.proto = UDP_PROTO_NUM;
            default: t.proto = 8'($urandom);
        endcase
        return t;
    endfunction

    task automatic random_traffic(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (i == n / 2) drain();
            if (r < 25) tick();
            else if (r < 85)
                packet(pool[$urandom_range(POOL - 1)], 1'($urandom), 4'($urandom));
            else if (r < 95) begin
                pool[$urandom_range(POOL - 1)] = fresh_tuple();
                packet(pool[$urandom_range(POOL - 1)], 1'($urandom), 4'($urandom));
            end else packet(fresh_tuple(), 1'b0, 4'($urandom));
        end
    endtask

    initial begin
        tuple_t t;
        foreach (pool[i]) pool[i] = fresh_tuple();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle = 19;
        rx_idle = 54;
        t = '{32'h0, 32'h0, 16'h0, 16'h0, UDP_PROTO_NUM};
        packet(t, 1'b0, 4'h0);
        packet(t, 1'b1, 4'h0);
        t = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
        packet(t, 1'b0, 4'hF);
        packet(t, 1'b0, 4'h0);
        t = '{32'h0A00_0001, 32'hC0A8_0101, 16'd40000, 16'd443, TCP_PROTO_NUM};
        packet(t, 1'b0, 4'b0001);
        packet(t, 1'b1, 4'b0011);
        packet(t, 1'b0, 4'b0010);
        packet(t, 1'b0, 4'b0000);
        packet(t, 1'b1, 4'b0100);
        packet(t, 1'b0, 4'b1000);
        packet(t, 1'b0, 4'b0001);
        t = '{32'h0A00_0002, 32'h0A00_0003, 16'd0, 16'd0, 8'd1};
        packet(t, 1'b0, 4'h0);
        packet(t, 1'b1, 4'h0);
        repeat (3) tick();

        configure(0, 1048575, 0, 1048575, 0, 65535, 0);
        packet(fresh_tuple(), 1'b0, 4'b0001);
        tick();
        configure(1048575, 0, 1048575, 0, 1048575, 0, 2047);
        packet(fresh_tuple(), 1'b0, 4'b0001);
        repeat (2) tick();

        configure(40, 8, 5, 0, 0, 1, 6);
        random_traffic(620);

        tx_idle = 54;
        rx_idle = 19;
        configure(1048575, 3, 1048575, 2, 1, 0, 2047);
        random_traffic(620);

        tx_idle = 0;
        rx_idle = 0;
        configure(20, 10, 6, 4, 2, 7, 1024);
        random_traffic(620);

        drain();
        repeat (ENTRIES + 10) @(posedge aclk);
        if (failures == 0) $display("** flow_connection_tracker: PASSED **");
        else $display("** flow_connection_tracker: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fct_pkg.sv
src/fct_ram.sv
src/fct_engine.sv
src/flow_connection_tracker.sv
bench/tb_fct_pkg.sv
bench/fct_checker.sv
bench/tb_flow_connection_tracker.sv
